// ----- rtl/number_property_classifier_unit_assert.svh -----
// Assertion macros shared by the checker of the number property classifier.
// Depends on signals named clk and rst_n in the scope that uses the macros.
`ifndef NUMBER_PROPERTY_CLASSIFIER_UNIT_ASSERT_SVH
`define NUMBER_PROPERTY_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define NPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npc assertion failed");

// Next-cycle implication, quiet during reset.
`define NPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npc assertion failed");

`endif

// ----- rtl/npc_pkg.sv -----
// Package of the number property classifier: sequencer states and constants.
// No dependencies; imported by the top level.
package npc_pkg;

    localparam int unsigned COUNT_W        = 3;  // distinct prime count, saturating
    localparam int unsigned SPHENIC_PRIMES = 3;  // primes in a sphenic number
    localparam int unsigned FIRST_PRIME    = 2;  // first trial divisor when factoring

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_LAUNCH,
        ST_SCAN_WAIT,
        ST_FACT_INIT,
        ST_FACT_LAUNCH,
        ST_FACT_WAIT,
        ST_FLUSH
    } npc_state_t;

endpackage

// ----- rtl/npc_if.sv -----
// Valid/ready channels of the number property classifier.
// No dependencies; used by the top level.
interface npc_sample_if #(parameter int VALUE_WIDTH = 8);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface npc_verdict_if;
    logic valid;
    logic ready;
    logic is_perfect;
    logic is_prime;
    logic is_square;
    logic is_sphenic;

    modport source (output valid, output is_perfect, output is_prime, output is_square,
                    output is_sphenic, input ready);
    modport sink   (input valid, input is_perfect, input is_prime, input is_square,
                    input is_sphenic, output ready);
endinterface

// ----- rtl/number_property_classifier_unit.sv -----
// Top level of the number property classifier: sequencer around one shared divider.
// Depends on npc_pkg, npc_if.sv and npc_divider.
//
//  port     dir   payload                                     accepted when
//  -------  ----  ------------------------------------------  -------------------
//  sample   sink  value[VALUE_WIDTH-1:0]                      valid && ready
//  verdict  src   is_perfect, is_prime, is_square, is_sphenic valid && ready
//
// One division runs as a launch, VALUE_WIDTH quotient steps and done. An item
//   costs floor(v/2) divisions in the divisor scan plus at most about sqrt(v) +
//   number of prime factors divisions in the factoring pass.
// Every trial division passes through the single divider.
// Reset clears the sequencer, the divider control and the verdict valid flag.
// sample.ready is high only in idle; a stalled verdict holds the next result in
//   the flush state until the earlier one transfers.
module number_property_classifier_unit
    import npc_pkg::*;
#(
    parameter int VALUE_WIDTH = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    npc_sample_if.sink    sample,
    npc_verdict_if.source verdict
);

    localparam int W = VALUE_WIDTH;

    npc_state_t state_reg, state_next;

    // item and loop registers
    logic [W-1:0]       value_reg,  value_next;
    logic [W-1:0]       d_reg,      d_next;      // trial divisor
    logic [W-1:0]       m_reg,      m_next;      // remaining cofactor while factoring
    logic [W:0]         sum_reg,    sum_next;    // proper divisor sum
    logic               over_reg,   over_next;   // sum already exceeds the value
    logic               found_reg,  found_next;  // divisor in 2..v/2 seen
    logic               square_reg, square_next;
    logic [COUNT_W-1:0] count_reg,  count_next;  // distinct primes found
    logic               sqfree_reg, sqfree_next;
    logic               hit_reg,    hit_next;    // current d already divided m

    // verdict output register
    logic v_valid_reg, v_valid_next;
    logic v_perf_reg,  v_perf_next;
    logic v_prime_reg, v_prime_next;
    logic v_sq_reg,    v_sq_next;
    logic v_sph_reg,   v_sph_next;

    logic         div_start;
    logic [W-1:0] div_dividend;
    logic         div_done;
    logic [W-1:0] div_quot;
    logic [W-1:0] div_rem;

    logic         accept;
    logic         out_free;
    logic [W-1:0] half;
    logic [W-1:0] in_half;
    logic         rem_zero;
    logic [W:0]   sum_try;
    logic [COUNT_W-1:0] count_inc;

    npc_divider #(.WIDTH(W)) u_npc_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (d_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign accept    = sample.valid && sample.ready;
    assign out_free  = !v_valid_reg || verdict.ready;
    assign half      = value_reg >> 1;
    assign in_half   = sample.value >> 1;
    assign rem_zero  = (div_rem == '0);
    assign sum_try   = sum_reg + {1'b0, d_reg};
    // saturate so wide parameter values cannot wrap the prime count
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_half == '0) ? ST_FACT_INIT : ST_SCAN_LAUNCH;
                end
            end
            ST_SCAN_LAUNCH:
            begin
                state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (d_reg == half) ? ST_FACT_INIT : ST_SCAN_LAUNCH;
                end
            end
            ST_FACT_INIT:
            begin
                state_next = (value_reg > W'(1)) ? ST_FACT_LAUNCH : ST_FLUSH;
            end
            ST_FACT_LAUNCH:
            begin
                state_next = ST_FACT_WAIT;
            end
            ST_FACT_WAIT:
            begin
                if (div_done)
                begin
                    priority if (rem_zero && div_quot == W'(1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (!rem_zero && div_quot < d_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_FACT_LAUNCH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample.ready = 1'b0;
        div_start    = 1'b0;
        div_dividend = value_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample.ready = 1'b1;
            end
            ST_SCAN_LAUNCH:
            begin
                div_start = 1'b1;
            end
            ST_FACT_LAUNCH:
            begin
                div_start    = 1'b1;
                div_dividend = m_reg;
            end
            ST_FACT_WAIT:
            begin
                div_dividend = m_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        value_next   = value_reg;
        d_next       = d_reg;
        m_next       = m_reg;
        sum_next     = sum_reg;
        over_next    = over_reg;
        found_next   = found_reg;
        square_next  = square_reg;
        count_next   = count_reg;
        sqfree_next  = sqfree_reg;
        hit_next     = hit_reg;
        v_perf_next  = v_perf_reg;
        v_prime_next = v_prime_reg;
        v_sq_next    = v_sq_reg;
        v_sph_next   = v_sph_reg;

        // drop the verdict once it transfers
        v_valid_next = (v_valid_reg && verdict.ready) ? 1'b0 : v_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next  = sample.value;
                    d_next      = W'(1);
                    sum_next    = '0;
                    over_next   = 1'b0;
                    found_next  = 1'b0;
                    // one is the square of one; the scan never reaches it
                    square_next = (sample.value == W'(1));
                end
            end
            ST_SCAN_WAIT:
            begin
                if (div_done)
                begin
                    if (rem_zero)
                    begin
                        if (!over_reg)
                        begin
                            if (sum_try > {1'b0, value_reg})
                            begin
                                over_next = 1'b1;
                            end
                            else
                            begin
                                sum_next = sum_try;
                            end
                        end
                        if (d_reg != W'(1))
                        begin
                            found_next = 1'b1;
                        end
                        if (div_quot == d_reg)
                        begin
                            square_next = 1'b1;
                        end
                    end
                    d_next = d_reg + W'(1);
                end
            end
            ST_FACT_INIT:
            begin
                m_next      = value_reg;
                d_next      = W'(FIRST_PRIME);
                count_next  = '0;
                sqfree_next = 1'b1;
                hit_next    = 1'b0;
            end
            ST_FACT_WAIT:
            begin
                if (div_done)
                begin
                    if (rem_zero)
                    begin
                        // repeated factor breaks square-freeness
                        if (hit_reg)
                        begin
                            sqfree_next = 1'b0;
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                        hit_next = 1'b1;
                        m_next   = div_quot;
                    end
                    else if (div_quot < d_reg)
                    begin
                        // cofactor below d squared with no smaller factor: a new prime
                        count_next = count_inc;
                    end
                    else
                    begin
                        d_next   = d_reg + W'(1);
                        hit_next = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    v_valid_next = 1'b1;
                    v_perf_next  = !over_reg && (sum_reg == {1'b0, value_reg})
                                   && (value_reg != '0);
                    v_prime_next = (value_reg >= W'(FIRST_PRIME)) && !found_reg;
                    v_sq_next    = square_reg;
                    v_sph_next   = (count_reg == COUNT_W'(SPHENIC_PRIMES)) && sqfree_reg;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            v_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            v_valid_reg <= v_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        d_reg       <= d_next;
        m_reg       <= m_next;
        sum_reg     <= sum_next;
        over_reg    <= over_next;
        found_reg   <= found_next;
        square_reg  <= square_next;
        count_reg   <= count_next;
        sqfree_reg  <= sqfree_next;
        hit_reg     <= hit_next;
        v_perf_reg  <= v_perf_next;
        v_prime_reg <= v_prime_next;
        v_sq_reg    <= v_sq_next;
        v_sph_reg   <= v_sph_next;
    end

    assign verdict.valid      = v_valid_reg;
    assign verdict.is_perfect = v_perf_reg;
    assign verdict.is_prime   = v_prime_reg;
    assign verdict.is_square  = v_sq_reg;
    assign verdict.is_sphenic = v_sph_reg;

endmodule

// ----- rtl/npc_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, shared by the classifier.
// No dependencies; instantiated by number_property_classifier_unit.
module npc_divider #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quot,
    output logic [WIDTH-1:0] rem
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] dsr_reg;

    logic [WIDTH:0]   partial;
    logic             fits;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_next;

    always_comb
    begin
        partial  = {rem_reg, quo_reg[WIDTH-1]};
        fits     = partial >= {1'b0, dsr_reg};
        diff     = partial - {1'b0, dsr_reg};
        rem_next = fits ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/npc_checker.sv -----
// Port-level checker of the number property classifier, bound to the top level.
// Depends on number_property_classifier_unit_assert.svh.
`include "number_property_classifier_unit_assert.svh"

module npc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic is_perfect,
    input logic is_prime,
    input logic is_square,
    input logic is_sphenic
);

    logic [3:0] flags;
    logic       others_set;

    assign flags      = {is_perfect, is_prime, is_square, is_sphenic};
    assign others_set = is_perfect || is_square || is_sphenic;

    // hold a stalled verdict
    `NPC_ASSERT_NEXT(a_verdict_hold, out_valid && !out_ready, out_valid && $stable(flags))

    // a prime is never perfect, square or sphenic
    `NPC_ASSERT_IMPL(a_prime_exclusive, out_valid && is_prime, !others_set)

    // busy right after a transfer in
    `NPC_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

    // no verdict appears the cycle after a transfer in
    `NPC_ASSERT_IMPL(a_no_instant_verdict, $rose(out_valid), !$past(in_valid && in_ready))

endmodule

bind number_property_classifier_unit npc_checker u_npc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (verdict.valid),
    .out_ready  (verdict.ready),
    .is_perfect (verdict.is_perfect),
    .is_prime   (verdict.is_prime),
    .is_square  (verdict.is_square),
    .is_sphenic (verdict.is_sphenic)
);

// ----- verif/npc_verdict_checker.sv -----
`timescale 1ns / 100ps
// Verdict checker for number_property_classifier_unit: predicts the four number
// properties of every accepted sample and compares each verdict transfer in order.
// Depends on the channel interfaces in npc_if.sv.
module npc_verdict_checker #(
    parameter int VALUE_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    npc_sample_if       sample,
    npc_verdict_if      verdict,
    output int unsigned error_count,
    output int unsigned pending_count,
    output int unsigned verdict_count,
    output int unsigned prime_count,
    output int unsigned square_count,
    output int unsigned sphenic_count,
    output int unsigned perfect_count
);

    typedef struct packed {
        logic perfect;
        logic prime;
        logic square;
        logic sphenic;
    } number_props_t;

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        number_props_t          props;
    } awaited_verdict_t;

    awaited_verdict_t awaited_q[$];

    // Trial division over 2 .. v/2; values below two are not prime.
    function automatic bit trial_prime(input int unsigned v);
        int unsigned d;
        if (v < 2)
            return 1'b0;
        for (d = 2; d <= v / 2; d++)
            if (v % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic number_props_t classify(input logic [VALUE_WIDTH-1:0] value);
        int unsigned   v;
        int unsigned   d;
        int unsigned   divisor_sum;
        int unsigned   root;
        int unsigned   factor_prod;
        int unsigned   factor_cnt;
        number_props_t p;
        v = 32'(value);
        p = '0;
        if (v == 0)
            return p;
        divisor_sum = 0;
        for (d = 1; d < v; d++)
            if (v % d == 0)
                divisor_sum += d;
        p.perfect = (divisor_sum == v);
        p.prime   = trial_prime(v);
        for (root = 1; root * root <= v; root++)
            if (root * root == v)
                p.square = 1'b1;
        // Sphenic: exactly three distinct prime divisors whose product is the value.
        factor_prod = 1;
        factor_cnt  = 0;
        for (d = 2; d <= v / 2; d++)
        begin
            if (v % d == 0 && trial_prime(d))
            begin
                factor_prod *= d;
                factor_cnt++;
            end
        end
        p.sphenic = (factor_cnt == 3) && (factor_prod == v);
        return p;
    endfunction

    initial
    begin
        error_count   = 0;
        pending_count = 0;
        verdict_count = 0;
        prime_count   = 0;
        square_count  = 0;
        sphenic_count = 0;
        perfect_count = 0;
    end

    always @(posedge clk)
    begin
        awaited_verdict_t head;
        number_props_t    seen;
        if (rst_n)
        begin
            // Retire the verdict first: a sample in the same cycle is always a later item.
            if (verdict.valid && verdict.ready)
            begin
                seen = {verdict.is_perfect, verdict.is_prime, verdict.is_square,
                        verdict.is_sphenic};
                verdict_count++;
                if (awaited_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: verdict with no sample waiting, got %b", $time, seen);
                end
                else
                begin
                    head = awaited_q.pop_front();
                    prime_count   += 32'(head.props.prime);
                    square_count  += 32'(head.props.square);
                    sphenic_count += 32'(head.props.sphenic);
                    perfect_count += 32'(head.props.perfect);
                    if (seen.perfect !== head.props.perfect || seen.prime !== head.props.prime
                        || seen.square !== head.props.square
                        || seen.sphenic !== head.props.sphenic)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: value %0d perfect/prime/square/sphenic exp %b got %b",
                                     $time, head.value, head.props, seen);
                    end
                end
            end
            if (sample.valid && sample.ready)
                awaited_q.push_back('{sample.value, classify(sample.value)});
            pending_count = awaited_q.size();
        end
    end

endmodule

// ----- verif/tb_number_property_classifier_unit.sv -----
`timescale 1ns / 100ps
// Testbench top for number_property_classifier_unit: drives the sample channel and
// verdict back-pressure, and gives the verdict. Depends on npc_if.sv, npc_verdict_checker.
module tb_number_property_classifier_unit;

    localparam int VALUE_WIDTH  = 8;
    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 560;
    // At the slowest item time, 583 items plus the longest gaps on both sides come
    // to about 9 ms, so allow several times that.
    localparam int RUN_LIMIT_NS = 50_000_000;

    logic        clk;
    logic        rst_n;
    bit          stalls_on;
    int unsigned sent_count;

    int unsigned error_count;
    int unsigned pending_count;
    int unsigned verdict_count;
    int unsigned prime_count;
    int unsigned square_count;
    int unsigned sphenic_count;
    int unsigned perfect_count;

    // Every sphenic number that fits in eight bits.
    int unsigned sphenic_set [0:24] = '{30, 42, 66, 70, 78, 102, 105, 110, 114, 130, 138,
                                        154, 165, 170, 174, 182, 186, 190, 195, 222, 230,
                                        231, 238, 246, 255};

    // The largest value with every bit set, the value one, smallest and largest primes,
    // perfect numbers, squares and sphenic numbers at both ends of the range.
    int unsigned directed_values [0:22] = '{1, 2, 3, 4, 6, 28, 30, 255, 254, 251, 225, 196,
                                            128, 127, 64, 42, 66, 12, 8, 9, 16, 170, 105};

    npc_sample_if #(.VALUE_WIDTH(VALUE_WIDTH)) sample_ch ();
    npc_verdict_if                             verdict_ch ();

    number_property_classifier_unit #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .verdict (verdict_ch)
    );

    npc_verdict_checker #(.VALUE_WIDTH(VALUE_WIDTH)) verdict_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample_ch),
        .verdict       (verdict_ch),
        .error_count   (error_count),
        .pending_count (pending_count),
        .verdict_count (verdict_count),
        .prime_count   (prime_count),
        .square_count  (square_count),
        .sphenic_count (sphenic_count),
        .perfect_count (perfect_count)
    );

    initial
        clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Value mix: full range, a share of small values to keep the run short, and
    // squares and sphenic numbers so the rare flags come up often.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int unsigned r;
        int unsigned root;
        r = $urandom_range(0, 99);
        if (r < 45)
            return VALUE_WIDTH'($urandom_range(1, (1 << VALUE_WIDTH) - 1));
        if (r < 80)
            return VALUE_WIDTH'($urandom_range(1, 63));
        if (r < 90)
        begin
            root = $urandom_range(1, 15);
            return VALUE_WIDTH'(root * root);
        end
        return VALUE_WIDTH'(sphenic_set[$urandom_range(0, 24)]);
    endfunction

    // Hold valid low for the gap, then present the value and hold it until the
    // transfer; return on the following falling edge.
    task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input int unsigned gap);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.value <= v;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // Verdict back-pressure: drop ready for random stretches while stalls are on,
    // otherwise hold it high.
    initial
    begin
        int unsigned hold_left;
        hold_left        = 0;
        verdict_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                verdict_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                verdict_ch.ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 7) == 0)
                    hold_left = idle_length();
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        bit calm;
        rst_n           = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.value = '0;
        stalls_on       = 1'b0;
        sent_count      = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed values back to back with the verdict side always ready.
        foreach (directed_values[i])
            send_value(VALUE_WIDTH'(directed_values[i]), 0);

        // Random values; a stretch in the middle runs with no idling on either side.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm      = (i >= 200 && i < 280);
            stalls_on = !calm;
            send_value(pick_value(), calm ? 0 : idle_length());
        end
        sample_ch.valid <= 1'b0;

        // Drain outstanding verdicts, then watch a little longer for strays.
        while (pending_count != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("classified %0d values, %0d verdicts checked, %0d errors", sent_count,
                 verdict_count, error_count);
        $display("flags expected: %0d prime, %0d square, %0d sphenic, %0d perfect",
                 prime_count, square_count, sphenic_count, perfect_count);
        if (error_count == 0)
            $display("tb_number_property_classifier_unit: clean");
        else
            $display("tb_number_property_classifier_unit: errors");
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("watchdog expired with %0d verdicts still due", pending_count);
        $display("tb_number_property_classifier_unit: errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/npc_pkg.sv
rtl/npc_if.sv
rtl/npc_divider.sv
rtl/number_property_classifier_unit.sv
rtl/npc_checker.sv
verif/npc_verdict_checker.sv
verif/tb_number_property_classifier_unit.sv
